>>> hdl/elastic_disk_collision_resolve_macros.svh
// Assertion helpers shared by the collision pipeline.
`ifndef ELASTIC_DISK_COLLISION_RESOLVE_MACROS_SVH
`define ELASTIC_DISK_COLLISION_RESOLVE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ECR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) else $error(msg);

`endif

>>> hdl/ecr_pkg.sv
package ecr_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NormBits = 60 - CoordW;
  localparam int unsigned MassW = 16;
  localparam int unsigned RootW = CoordW + 1;
  localparam int unsigned QuotW = 36;

  localparam int unsigned SIn = 0;
  localparam int unsigned SDif = 1;
  localparam int unsigned SSqr = 2;
  localparam int unsigned SSum = 3;
  localparam int unsigned SRt0 = 4;
  localparam int unsigned SNum = SRt0 + RootW;
  localparam int unsigned SDv0 = SNum + 1;
  localparam int unsigned SNrm = SDv0 + QuotW;
  localparam int unsigned SPrj = SNrm + 1;
  localparam int unsigned SRnd = SPrj + 1;
  localparam int unsigned SMd = SRnd + 1;
  localparam int unsigned SMm = SMd + 1;
  localparam int unsigned SDm0 = SMm + 1;
  localparam int unsigned SUpd = SDm0 + QuotW;
  localparam int unsigned SPr2 = SUpd + 1;
  localparam int unsigned SRb = SPr2 + 1;
  localparam int unsigned SOut = SRb + 1;
  localparam int unsigned Latency = SOut + 1;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic [15:0]        a_mass;
    logic [30:0]        a_radius;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [15:0]        b_mass;
    logic [30:0]        b_radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] a_new_pos_x;
    logic signed [31:0] a_new_pos_y;
    logic signed [31:0] a_new_vel_x;
    logic signed [31:0] a_new_vel_y;
    logic signed [31:0] b_new_pos_x;
    logic signed [31:0] b_new_pos_y;
    logic signed [31:0] b_new_vel_x;
    logic signed [31:0] b_new_vel_y;
    logic               coincident;
  } out_t;

  typedef struct packed {
    in_t                in;
    logic               coin;
    logic               dxn;
    logic               dyn;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [65:0]        rem;
    logic [32:0]        root;
    logic signed [35:0] ov;
    logic [60:0]        r0;
    logic [60:0]        r1;
    logic [32:0]        dv;
    logic [35:0]        q0;
    logic [35:0]        q1;
    logic signed [29:0] nx;
    logic signed [29:0] ny;
    logic [9:0][67:0]   p;
    logic signed [35:0] v1n;
    logic signed [35:0] v1t;
    logic signed [35:0] v2n;
    logic signed [35:0] v2t;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic               dn;
    logic [35:0]        um;
    logic [16:0]        s;
    logic [17:0]        ka;
    logic [17:0]        kb;
    logic signed [37:0] n1;
    logic signed [37:0] n2;
    logic [7:0][39:0]   w;
    out_t               res;
  } ctx_t;

  function automatic logic signed [67:0] rsh(input logic signed [67:0] v,
                                             input int unsigned sh);
    logic [67:0] m;
    logic [67:0] r;
    m = v[67] ? 68'(-v) : 68'(v);
    r = (m + (68'(1) << (sh - 1))) >> sh;
    return v[67] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [39:0] v);
    if (v > 40'sh007fffffff) begin
      return 32'sh7fffffff;
    end else if (v < -40'sh0080000000) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

>>> hdl/elastic_disk_collision_resolve.sv
// Resolves the elastic collision of two disks in a fully pipelined datapath. A pair is taken
// whenever start is high; busy is never raised, so one pair may follow another in every
// cycle. Each pair yields one result on done_o after its transfer, in order. Most of the
// pipeline is the bit-per-stage square root (33 stages) and the two bit-per-stage
// restoring dividers (36 stages each) for the unit normal and the mass exchange.
// Results cannot be held off, so the receiver must take every done_o cycle.
`include "elastic_disk_collision_resolve_macros.svh"

module elastic_disk_collision_resolve (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ecr_pkg::in_t  disks_i,
  output logic          done_o,
  output ecr_pkg::out_t result_o
);

  ecr_pkg::ctx_t ctx_q [ecr_pkg::SOut+1];
  ecr_pkg::ctx_t ctx_d [ecr_pkg::SOut+1];
  logic [ecr_pkg::SOut:0] vld_q;

  assign busy = 1'b0;

  always_comb begin
    logic [66:0] cand;
    logic [68:0] dcand;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [36:0] dd;
    logic [16:0] ma;
    logic [16:0] mb;
    logic signed [37:0] m1;
    logic signed [37:0] m2;
    int unsigned b;

    ctx_d[0] = ctx_q[0];
    ctx_d[0].in = disks_i;
    for (int k = 1; k <= ecr_pkg::SOut; k++) begin
      ctx_d[k] = ctx_q[k-1];
    end

    dx = 33'(ctx_q[ecr_pkg::SIn].in.b_pos_x) - 33'(ctx_q[ecr_pkg::SIn].in.a_pos_x);
    dy = 33'(ctx_q[ecr_pkg::SIn].in.b_pos_y) - 33'(ctx_q[ecr_pkg::SIn].in.a_pos_y);
    ctx_d[ecr_pkg::SDif].dxn = dx[32];
    ctx_d[ecr_pkg::SDif].dyn = dy[32];
    ctx_d[ecr_pkg::SDif].adx = dx[32] ? 32'(-dx) : 32'(dx);
    ctx_d[ecr_pkg::SDif].ady = dy[32] ? 32'(-dy) : 32'(dy);
    ctx_d[ecr_pkg::SDif].coin = (dx == 33'sd0) && (dy == 33'sd0);

    ctx_d[ecr_pkg::SSqr].sqx = 64'(ctx_q[ecr_pkg::SDif].adx) * 64'(ctx_q[ecr_pkg::SDif].adx);
    ctx_d[ecr_pkg::SSqr].sqy = 64'(ctx_q[ecr_pkg::SDif].ady) * 64'(ctx_q[ecr_pkg::SDif].ady);

    ctx_d[ecr_pkg::SSum].rem = 66'(ctx_q[ecr_pkg::SSqr].sqx) + 66'(ctx_q[ecr_pkg::SSqr].sqy);
    ctx_d[ecr_pkg::SSum].root = '0;

    for (int j = 0; j < ecr_pkg::RootW; j++) begin
      b = ecr_pkg::RootW - 1 - j;
      cand = (67'(ctx_q[ecr_pkg::SRt0+j-1].root) << (b + 1)) + (67'(1) << (2 * b));
      if (67'(ctx_q[ecr_pkg::SRt0+j-1].rem) >= cand) begin
        ctx_d[ecr_pkg::SRt0+j].rem = 66'(67'(ctx_q[ecr_pkg::SRt0+j-1].rem) - cand);
        ctx_d[ecr_pkg::SRt0+j].root = ctx_q[ecr_pkg::SRt0+j-1].root | (33'(1) << b);
      end
    end

    ctx_d[ecr_pkg::SNum].r0 = (61'(ctx_q[ecr_pkg::SNum-1].adx) << ecr_pkg::NormBits)
                              + 61'(ctx_q[ecr_pkg::SNum-1].root >> 1);
    ctx_d[ecr_pkg::SNum].r1 = (61'(ctx_q[ecr_pkg::SNum-1].ady) << ecr_pkg::NormBits)
                              + 61'(ctx_q[ecr_pkg::SNum-1].root >> 1);
    ctx_d[ecr_pkg::SNum].dv = ctx_q[ecr_pkg::SNum-1].root;
    ctx_d[ecr_pkg::SNum].q0 = '0;
    ctx_d[ecr_pkg::SNum].q1 = '0;
    ctx_d[ecr_pkg::SNum].ov = $signed(36'(ctx_q[ecr_pkg::SNum-1].in.a_radius)
                              + 36'(ctx_q[ecr_pkg::SNum-1].in.b_radius)
                              - 36'(ctx_q[ecr_pkg::SNum-1].root)
                              + (36'(1) << (ecr_pkg::FracBits - 1)));

    for (int j = 0; j < ecr_pkg::QuotW; j++) begin
      b = ecr_pkg::QuotW - 1 - j;
      dcand = 69'(ctx_q[ecr_pkg::SDv0+j-1].dv) << b;
      if (69'(ctx_q[ecr_pkg::SDv0+j-1].r0) >= dcand) begin
        ctx_d[ecr_pkg::SDv0+j].r0 = 61'(69'(ctx_q[ecr_pkg::SDv0+j-1].r0) - dcand);
        ctx_d[ecr_pkg::SDv0+j].q0 = ctx_q[ecr_pkg::SDv0+j-1].q0 | (36'(1) << b);
      end
      if (69'(ctx_q[ecr_pkg::SDv0+j-1].r1) >= dcand) begin
        ctx_d[ecr_pkg::SDv0+j].r1 = 61'(69'(ctx_q[ecr_pkg::SDv0+j-1].r1) - dcand);
        ctx_d[ecr_pkg::SDv0+j].q1 = ctx_q[ecr_pkg::SDv0+j-1].q1 | (36'(1) << b);
      end
      dcand = 69'(ctx_q[ecr_pkg::SDm0+j-1].dv) << b;
      if (69'(ctx_q[ecr_pkg::SDm0+j-1].r0) >= dcand) begin
        ctx_d[ecr_pkg::SDm0+j].r0 = 61'(69'(ctx_q[ecr_pkg::SDm0+j-1].r0) - dcand);
        ctx_d[ecr_pkg::SDm0+j].q0 = ctx_q[ecr_pkg::SDm0+j-1].q0 | (36'(1) << b);
      end
      if (69'(ctx_q[ecr_pkg::SDm0+j-1].r1) >= dcand) begin
        ctx_d[ecr_pkg::SDm0+j].r1 = 61'(69'(ctx_q[ecr_pkg::SDm0+j-1].r1) - dcand);
        ctx_d[ecr_pkg::SDm0+j].q1 = ctx_q[ecr_pkg::SDm0+j-1].q1 | (36'(1) << b);
      end
    end

    ctx_d[ecr_pkg::SNrm].nx = ctx_q[ecr_pkg::SNrm-1].dxn ?
                              -$signed(30'(ctx_q[ecr_pkg::SNrm-1].q0)) :
                              $signed(30'(ctx_q[ecr_pkg::SNrm-1].q0));
    ctx_d[ecr_pkg::SNrm].ny = ctx_q[ecr_pkg::SNrm-1].dyn ?
                              -$signed(30'(ctx_q[ecr_pkg::SNrm-1].q1)) :
                              $signed(30'(ctx_q[ecr_pkg::SNrm-1].q1));

    ctx_d[ecr_pkg::SPrj].p[0] = 68'(ctx_q[ecr_pkg::SNrm].in.a_vel_x * ctx_q[ecr_pkg::SNrm].nx);
    ctx_d[ecr_pkg::SPrj].p[1] = 68'(ctx_q[ecr_pkg::SNrm].in.a_vel_y * ctx_q[ecr_pkg::SNrm].ny);
    ctx_d[ecr_pkg::SPrj].p[2] = 68'(ctx_q[ecr_pkg::SNrm].in.a_vel_y * ctx_q[ecr_pkg::SNrm].nx);
    ctx_d[ecr_pkg::SPrj].p[3] = 68'(ctx_q[ecr_pkg::SNrm].in.a_vel_x * ctx_q[ecr_pkg::SNrm].ny);
    ctx_d[ecr_pkg::SPrj].p[4] = 68'(ctx_q[ecr_pkg::SNrm].in.b_vel_x * ctx_q[ecr_pkg::SNrm].nx);
    ctx_d[ecr_pkg::SPrj].p[5] = 68'(ctx_q[ecr_pkg::SNrm].in.b_vel_y * ctx_q[ecr_pkg::SNrm].ny);
    ctx_d[ecr_pkg::SPrj].p[6] = 68'(ctx_q[ecr_pkg::SNrm].in.b_vel_y * ctx_q[ecr_pkg::SNrm].nx);
    ctx_d[ecr_pkg::SPrj].p[7] = 68'(ctx_q[ecr_pkg::SNrm].in.b_vel_x * ctx_q[ecr_pkg::SNrm].ny);
    ctx_d[ecr_pkg::SPrj].p[8] = 68'(ctx_q[ecr_pkg::SNrm].ov * ctx_q[ecr_pkg::SNrm].nx);
    ctx_d[ecr_pkg::SPrj].p[9] = 68'(ctx_q[ecr_pkg::SNrm].ov * ctx_q[ecr_pkg::SNrm].ny);

    ctx_d[ecr_pkg::SRnd].v1n = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[0])
                               + $signed(ctx_q[ecr_pkg::SPrj].p[1]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRnd].v1t = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[2])
                               - $signed(ctx_q[ecr_pkg::SPrj].p[3]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRnd].v2n = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[4])
                               + $signed(ctx_q[ecr_pkg::SPrj].p[5]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRnd].v2t = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[6])
                               - $signed(ctx_q[ecr_pkg::SPrj].p[7]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRnd].sx = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[8]),
                              ecr_pkg::NormBits + 1));
    ctx_d[ecr_pkg::SRnd].sy = 36'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPrj].p[9]),
                              ecr_pkg::NormBits + 1));

    dd = 37'(ctx_q[ecr_pkg::SRnd].v2n) - 37'(ctx_q[ecr_pkg::SRnd].v1n);
    ma = 17'(ctx_q[ecr_pkg::SRnd].in.a_mass);
    mb = 17'(ctx_q[ecr_pkg::SRnd].in.b_mass);
    if ((ma == 17'd0) && (mb == 17'd0)) begin
      ma = 17'd1;
      mb = 17'd1;
    end
    ctx_d[ecr_pkg::SMd].dn = dd[36];
    ctx_d[ecr_pkg::SMd].um = dd[36] ? 36'(-dd) : 36'(dd);
    ctx_d[ecr_pkg::SMd].s = ma + mb;
    ctx_d[ecr_pkg::SMd].ka = {ma, 1'b0};
    ctx_d[ecr_pkg::SMd].kb = {mb, 1'b0};

    ctx_d[ecr_pkg::SMm].r0 = 61'(ctx_q[ecr_pkg::SMd].um) * 61'(ctx_q[ecr_pkg::SMd].kb)
                             + 61'(ctx_q[ecr_pkg::SMd].s >> 1);
    ctx_d[ecr_pkg::SMm].r1 = 61'(ctx_q[ecr_pkg::SMd].um) * 61'(ctx_q[ecr_pkg::SMd].ka)
                             + 61'(ctx_q[ecr_pkg::SMd].s >> 1);
    ctx_d[ecr_pkg::SMm].dv = 33'(ctx_q[ecr_pkg::SMd].s);
    ctx_d[ecr_pkg::SMm].q0 = '0;
    ctx_d[ecr_pkg::SMm].q1 = '0;

    m1 = ctx_q[ecr_pkg::SUpd-1].dn ? -$signed(38'(ctx_q[ecr_pkg::SUpd-1].q0)) :
         $signed(38'(ctx_q[ecr_pkg::SUpd-1].q0));
    m2 = ctx_q[ecr_pkg::SUpd-1].dn ? -$signed(38'(ctx_q[ecr_pkg::SUpd-1].q1)) :
         $signed(38'(ctx_q[ecr_pkg::SUpd-1].q1));
    ctx_d[ecr_pkg::SUpd].n1 = 38'(ctx_q[ecr_pkg::SUpd-1].v1n) + m1;
    ctx_d[ecr_pkg::SUpd].n2 = 38'(ctx_q[ecr_pkg::SUpd-1].v2n) - m2;

    ctx_d[ecr_pkg::SPr2].p[0] = 68'(ctx_q[ecr_pkg::SUpd].n1 * ctx_q[ecr_pkg::SUpd].nx);
    ctx_d[ecr_pkg::SPr2].p[1] = 68'(ctx_q[ecr_pkg::SUpd].v1t * ctx_q[ecr_pkg::SUpd].ny);
    ctx_d[ecr_pkg::SPr2].p[2] = 68'(ctx_q[ecr_pkg::SUpd].n1 * ctx_q[ecr_pkg::SUpd].ny);
    ctx_d[ecr_pkg::SPr2].p[3] = 68'(ctx_q[ecr_pkg::SUpd].v1t * ctx_q[ecr_pkg::SUpd].nx);
    ctx_d[ecr_pkg::SPr2].p[4] = 68'(ctx_q[ecr_pkg::SUpd].n2 * ctx_q[ecr_pkg::SUpd].nx);
    ctx_d[ecr_pkg::SPr2].p[5] = 68'(ctx_q[ecr_pkg::SUpd].v2t * ctx_q[ecr_pkg::SUpd].ny);
    ctx_d[ecr_pkg::SPr2].p[6] = 68'(ctx_q[ecr_pkg::SUpd].n2 * ctx_q[ecr_pkg::SUpd].ny);
    ctx_d[ecr_pkg::SPr2].p[7] = 68'(ctx_q[ecr_pkg::SUpd].v2t * ctx_q[ecr_pkg::SUpd].nx);

    ctx_d[ecr_pkg::SRb].w[0] = 40'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPr2].p[0])
                               - $signed(ctx_q[ecr_pkg::SPr2].p[1]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRb].w[1] = 40'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPr2].p[2])
                               + $signed(ctx_q[ecr_pkg::SPr2].p[3]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRb].w[2] = 40'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPr2].p[4])
                               - $signed(ctx_q[ecr_pkg::SPr2].p[5]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRb].w[3] = 40'(ecr_pkg::rsh($signed(ctx_q[ecr_pkg::SPr2].p[6])
                               + $signed(ctx_q[ecr_pkg::SPr2].p[7]), ecr_pkg::NormBits));
    ctx_d[ecr_pkg::SRb].w[4] = 40'(40'(ctx_q[ecr_pkg::SPr2].in.a_pos_x)
                               - 40'(ctx_q[ecr_pkg::SPr2].sx));
    ctx_d[ecr_pkg::SRb].w[5] = 40'(40'(ctx_q[ecr_pkg::SPr2].in.a_pos_y)
                               - 40'(ctx_q[ecr_pkg::SPr2].sy));
    ctx_d[ecr_pkg::SRb].w[6] = 40'(40'(ctx_q[ecr_pkg::SPr2].in.b_pos_x)
                               + 40'(ctx_q[ecr_pkg::SPr2].sx));
    ctx_d[ecr_pkg::SRb].w[7] = 40'(40'(ctx_q[ecr_pkg::SPr2].in.b_pos_y)
                               + 40'(ctx_q[ecr_pkg::SPr2].sy));

    if (ctx_q[ecr_pkg::SRb].coin) begin
      ctx_d[ecr_pkg::SOut].res.a_new_pos_x = ctx_q[ecr_pkg::SRb].in.a_pos_x;
      ctx_d[ecr_pkg::SOut].res.a_new_pos_y = ctx_q[ecr_pkg::SRb].in.a_pos_y;
      ctx_d[ecr_pkg::SOut].res.a_new_vel_x = ctx_q[ecr_pkg::SRb].in.a_vel_x;
      ctx_d[ecr_pkg::SOut].res.a_new_vel_y = ctx_q[ecr_pkg::SRb].in.a_vel_y;
      ctx_d[ecr_pkg::SOut].res.b_new_pos_x = ctx_q[ecr_pkg::SRb].in.b_pos_x;
      ctx_d[ecr_pkg::SOut].res.b_new_pos_y = ctx_q[ecr_pkg::SRb].in.b_pos_y;
      ctx_d[ecr_pkg::SOut].res.b_new_vel_x = ctx_q[ecr_pkg::SRb].in.b_vel_x;
      ctx_d[ecr_pkg::SOut].res.b_new_vel_y = ctx_q[ecr_pkg::SRb].in.b_vel_y;
    end else begin
      ctx_d[ecr_pkg::SOut].res.a_new_pos_x = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[4]));
      ctx_d[ecr_pkg::SOut].res.a_new_pos_y = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[5]));
      ctx_d[ecr_pkg::SOut].res.a_new_vel_x = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[0]));
      ctx_d[ecr_pkg::SOut].res.a_new_vel_y = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[1]));
      ctx_d[ecr_pkg::SOut].res.b_new_pos_x = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[6]));
      ctx_d[ecr_pkg::SOut].res.b_new_pos_y = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[7]));
      ctx_d[ecr_pkg::SOut].res.b_new_vel_x = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[2]));
      ctx_d[ecr_pkg::SOut].res.b_new_vel_y = ecr_pkg::sat($signed(ctx_q[ecr_pkg::SRb].w[3]));
    end
    ctx_d[ecr_pkg::SOut].res.coincident = ctx_q[ecr_pkg::SRb].coin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ecr_pkg::SOut-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= ecr_pkg::SOut; k++) begin
      ctx_q[k] <= ctx_d[k];
    end
  end

  assign done_o = vld_q[ecr_pkg::SOut];
  assign result_o = ctx_q[ecr_pkg::SOut].res;

  `ECR_ASSERT_IMP(a_latency, start && !busy, ##(ecr_pkg::Latency) done_o, "Result strobe missing after a transfer.")
  `ECR_ASSERT_IMP(a_coincident, start && !busy && (disks_i.a_pos_x == disks_i.b_pos_x) && (disks_i.a_pos_y == disks_i.b_pos_y), ##(ecr_pkg::Latency) (result_o.coincident && (result_o.a_new_vel_x == $past(disks_i.a_vel_x, ecr_pkg::Latency))), "Coincident pair was not passed through.")
  `ECR_ASSERT(a_norm_bound, !(vld_q[ecr_pkg::SNrm] && !ctx_q[ecr_pkg::SNrm].coin) || (ctx_q[ecr_pkg::SNrm].q0 <= (36'(1) << ecr_pkg::NormBits)), "Normal component exceeds unit length.")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned NumItems = 1600;
  localparam int unsigned CycleLimit = 400000;

  class collision_scoreboard;
    ecr_pkg::out_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function wide_t round_shift(wide_t v, int unsigned sh);
      wide_t m;
      wide_t r;
      m = (v < 0) ? -v : v;
      r = (m + (wide_t'(1) << (sh - 1))) >>> sh;
      return (v < 0) ? -r : r;
    endfunction

    function wide_t scale_div(wide_t d, wide_t k, wide_t s);
      wide_t u;
      wide_t r;
      u = (d < 0) ? -d : d;
      r = (u * k + s / 2) / s;
      return (d < 0) ? -r : r;
    endfunction

    function wide_t root_floor(wide_t x);
      wide_t res;
      wide_t c;
      res = 0;
      for (int b = 40; b >= 0; b--) begin
        c = res | (wide_t'(1) << b);
        if (c * c <= x) res = c;
      end
      return res;
    endfunction

    function logic signed [31:0] clamp(wide_t v);
      if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
      return v[31:0];
    endfunction

    function ecr_pkg::out_t resolve(ecr_pkg::in_t it);
      ecr_pkg::out_t o;
      wide_t ax, ay, avx, avy, bx, by, bvx, bvy, am, bm, ar, br;
      wide_t dx, dy, span, nx, ny, v1n, v1t, v2n, v2t, s, d, n1, n2, ov, sx, sy;
      ax = wide_t'(it.a_pos_x);   ay = wide_t'(it.a_pos_y);
      avx = wide_t'(it.a_vel_x);  avy = wide_t'(it.a_vel_y);
      bx = wide_t'(it.b_pos_x);   by = wide_t'(it.b_pos_y);
      bvx = wide_t'(it.b_vel_x);  bvy = wide_t'(it.b_vel_y);
      am = wide_t'(it.a_mass);    bm = wide_t'(it.b_mass);
      ar = wide_t'(it.a_radius);  br = wide_t'(it.b_radius);
      dx = bx - ax;
      dy = by - ay;
      if (dx == 0 && dy == 0) begin
        o.a_new_pos_x = it.a_pos_x; o.a_new_pos_y = it.a_pos_y;
        o.a_new_vel_x = it.a_vel_x; o.a_new_vel_y = it.a_vel_y;
        o.b_new_pos_x = it.b_pos_x; o.b_new_pos_y = it.b_pos_y;
        o.b_new_vel_x = it.b_vel_x; o.b_new_vel_y = it.b_vel_y;
        o.coincident = 1'b1;
        return o;
      end
      span = root_floor(dx * dx + dy * dy);
      nx = ((((dx < 0) ? -dx : dx) << ecr_pkg::NormBits) + span / 2) / span;
      if (dx < 0) nx = -nx;
      ny = ((((dy < 0) ? -dy : dy) << ecr_pkg::NormBits) + span / 2) / span;
      if (dy < 0) ny = -ny;
      v1n = round_shift(avx * nx + avy * ny, ecr_pkg::NormBits);
      v1t = round_shift(avy * nx - avx * ny, ecr_pkg::NormBits);
      v2n = round_shift(bvx * nx + bvy * ny, ecr_pkg::NormBits);
      v2t = round_shift(bvy * nx - bvx * ny, ecr_pkg::NormBits);
      if (am == 0 && bm == 0) begin
        am = 1;
        bm = 1;
      end
      s = am + bm;
      d = v2n - v1n;
      n1 = v1n + scale_div(d, 2 * bm, s);
      n2 = v2n - scale_div(d, 2 * am, s);
      ov = ar + br - span + (wide_t'(1) << (ecr_pkg::FracBits - 1));
      sx = round_shift(ov * nx, ecr_pkg::NormBits + 1);
      sy = round_shift(ov * ny, ecr_pkg::NormBits + 1);
      o.a_new_pos_x = clamp(ax - sx);
      o.a_new_pos_y = clamp(ay - sy);
      o.a_new_vel_x = clamp(round_shift(n1 * nx - v1t * ny, ecr_pkg::NormBits));
      o.a_new_vel_y = clamp(round_shift(n1 * ny + v1t * nx, ecr_pkg::NormBits));
      o.b_new_pos_x = clamp(bx + sx);
      o.b_new_pos_y = clamp(by + sy);
      o.b_new_vel_x = clamp(round_shift(n2 * nx - v2t * ny, ecr_pkg::NormBits));
      o.b_new_vel_y = clamp(round_shift(n2 * ny + v2t * nx, ecr_pkg::NormBits));
      o.coincident = 1'b0;
      return o;
    endfunction

    function void note_pair(ecr_pkg::in_t it);
      expected_q.push_back(resolve(it));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(ecr_pkg::out_t act);
      ecr_pkg::out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("a_new_pos_x", e.a_new_pos_x, act.a_new_pos_x);
      compare_field("a_new_pos_y", e.a_new_pos_y, act.a_new_pos_y);
      compare_field("a_new_vel_x", e.a_new_vel_x, act.a_new_vel_x);
      compare_field("a_new_vel_y", e.a_new_vel_y, act.a_new_vel_y);
      compare_field("b_new_pos_x", e.b_new_pos_x, act.b_new_pos_x);
      compare_field("b_new_pos_y", e.b_new_pos_y, act.b_new_pos_y);
      compare_field("b_new_vel_x", e.b_new_vel_x, act.b_new_vel_x);
      compare_field("b_new_vel_y", e.b_new_vel_y, act.b_new_vel_y);
      compare_field("coincident", 32'(e.coincident), 32'(act.coincident));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  ecr_pkg::in_t  disks_i;
  logic done_o;
  ecr_pkg::out_t result_o;

  collision_scoreboard sb;
  int unsigned cycles;

  elastic_disk_collision_resolve dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .disks_i  (disks_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    sb = new();
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni) begin
      if (start && !busy) sb.note_pair(disks_i);
      if (done_o) sb.check_result(result_o);
    end
  end

  function automatic ecr_pkg::in_t base_pair();
    ecr_pkg::in_t it;
    it.a_pos_x = 32'sh0001_0000; it.a_pos_y = 32'sh0002_0000;
    it.a_vel_x = 32'sh0003_0000; it.a_vel_y = -32'sh0001_0000;
    it.a_mass = 16'd3;           it.a_radius = 31'h0001_8000;
    it.b_pos_x = 32'sh0003_0000; it.b_pos_y = 32'sh0002_8000;
    it.b_vel_x = -32'sh0002_0000; it.b_vel_y = 32'sh0000_4000;
    it.b_mass = 16'd5;           it.b_radius = 31'h0001_0000;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_span(int unsigned bits);
    return $signed($urandom_range((1 << bits) - 1)) - $signed(1 << (bits - 1));
  endfunction

  function automatic ecr_pkg::in_t random_pair();
    ecr_pkg::in_t it;
    logic signed [31:0] ox, oy;
    if ($urandom_range(99) < 20) begin
      it.a_pos_x = $urandom(); it.a_pos_y = $urandom();
      it.a_vel_x = $urandom(); it.a_vel_y = $urandom();
      it.a_mass = 16'($urandom());  it.a_radius = 31'($urandom());
      it.b_pos_x = $urandom(); it.b_pos_y = $urandom();
      it.b_vel_x = $urandom(); it.b_vel_y = $urandom();
      it.b_mass = 16'($urandom());  it.b_radius = 31'($urandom());
      if ($urandom_range(9) == 0) begin
        it.b_pos_x = it.a_pos_x;
        it.b_pos_y = it.a_pos_y;
      end
      return it;
    end
    ox = rand_span($urandom_range(21, 2));
    oy = rand_span($urandom_range(21, 2));
    if (ox == 0 && oy == 0) ox = 1;
    it.a_pos_x = rand_span(25); it.a_pos_y = rand_span(25);
    it.b_pos_x = it.a_pos_x + ox; it.b_pos_y = it.a_pos_y + oy;
    it.a_vel_x = rand_span(23); it.a_vel_y = rand_span(23);
    it.b_vel_x = rand_span(23); it.b_vel_y = rand_span(23);
    it.a_mass = 16'($urandom_range(65535, 1));
    it.b_mass = 16'($urandom_range(65535, 1));
    it.a_radius = 31'($urandom_range(1 << 21));
    it.b_radius = 31'($urandom_range(1 << 21));
    return it;
  endfunction

  task automatic send_pair(ecr_pkg::in_t it, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    disks_i <= it;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    ecr_pkg::in_t it;
    int unsigned idle_pct;
    rst_ni = 1'b0;
    start = 1'b0;
    disks_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    it = base_pair();
    send_pair(it, 0);
    it.b_pos_x = it.a_pos_x; it.b_pos_y = it.a_pos_y;
    send_pair(it, 0);
    it = base_pair(); it.a_mass = 16'd0; it.b_mass = 16'd0;
    send_pair(it, 0);
    it = base_pair(); it.a_mass = 16'd0;
    send_pair(it, 0);
    it = base_pair(); it.b_mass = 16'd0;
    send_pair(it, 0);
    it = base_pair(); it.a_mass = 16'hffff; it.b_mass = 16'd1;
    send_pair(it, 0);
    it = base_pair(); it.b_pos_x = 32'sh0100_0000;
    send_pair(it, 0);
    it = base_pair(); it.b_pos_y = it.a_pos_y;
    send_pair(it, 0);
    it = base_pair(); it.b_pos_x = it.a_pos_x; it.b_pos_y = -32'sh0001_0000;
    send_pair(it, 0);
    it = base_pair(); it.b_pos_x = it.a_pos_x + 1;
    it.b_pos_y = it.a_pos_y;
    send_pair(it, 0);
    it = base_pair(); it.a_pos_x = 32'sh8000_0000; it.a_pos_y = 32'sh8000_0000;
    it.b_pos_x = 32'sh7fff_ffff; it.b_pos_y = 32'sh7fff_ffff;
    send_pair(it, 0);
    it.a_radius = '1; it.b_radius = '1;
    send_pair(it, 0);
    it = base_pair(); it.a_vel_x = 32'sh7fff_ffff; it.a_vel_y = 32'sh7fff_ffff;
    it.b_vel_x = 32'sh8000_0000; it.b_vel_y = 32'sh8000_0000;
    send_pair(it, 0);
    it.a_mass = 16'd1; it.b_mass = 16'hffff;
    send_pair(it, 0);
    it = base_pair(); it.a_radius = '0; it.b_radius = '0;
    send_pair(it, 0);
    it = base_pair(); it.a_radius = '1; it.b_radius = '1;
    it.a_pos_x = 32'sh7fff_0000; it.b_pos_x = 32'sh8000_0000;
    send_pair(it, 0);
    it.a_pos_x = 32'sh7fff_ffff; it.a_pos_y = 32'sh8000_0000;
    it.b_pos_x = 32'sh7fff_ffff; it.b_pos_y = 32'sh8000_0000;
    send_pair(it, 0);
    drain();

    for (int unsigned i = 0; i < NumItems; i++) begin
      if (i == NumItems / 3) drain();
      if (i < NumItems / 3) idle_pct = 22;
      else if (i < 2 * NumItems / 3) idle_pct = 49;
      else idle_pct = 0;
      send_pair(random_pair(), idle_pct);
    end
    drain();
    repeat (ecr_pkg::Latency + 20) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
